### src/mos_pkg.sv
// Package for the median-of-set unit: sizes, controller states and the
// command and status bundles between the controller and the datapath.
// No dependencies.
package mos_pkg;

    // Capacity of the sorted cell chain.
    localparam int MAX_SAMPLES = 64;

    // Field widths of an input item and a result item.
    localparam int SAMPLE_W    = 32;
    localparam int MEDIAN_W    = SAMPLE_W + 1;
    localparam int COUNT_OUT_W = 7;

    // The fill count must hold MAX_SAMPLES itself.
    localparam int CNT_W = $clog2(MAX_SAMPLES + 1);

    // Largest left shift before readout is (MAX_SAMPLES - 1) / 2.
    localparam int SHIFT_MAX = (MAX_SAMPLES - 1) / 2;
    localparam int SHIFT_W   = (SHIFT_MAX > 1) ? $clog2(SHIFT_MAX + 1) : 1;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_SHIFT,
        ST_EMIT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic insert;
        logic shift;
        logic emit;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [CNT_W-1:0] count;
    } t_dp_status;

endpackage

### src/median_of_set_unit.sv
// Top level of the median-of-set unit: joins the controller and the
// datapath. Depends on mos_pkg, mos_ctrl and mos_datapath.
//
// An item is taken when start is high and busy is low. An item without the
// last mark is placed into a sorted chain of 64 cells, so such items may
// follow each other in every cycle. A last-marked item closes the set:
// busy then stays high through the readout, while the cell chain shifts
// one place per cycle to bring the middle samples to its head. The result
// follows on o_median_value, o_sample_count and o_overflowed for one cycle,
// marked by o_done, in the first cycle after busy falls; it must be taken
// then, as nothing holds it. Samples beyond 64 are dropped and reported in
// o_overflowed.
module median_of_set_unit
    import mos_pkg::*;
(
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic signed [SAMPLE_W-1:0]  i_sample,
    input  logic                        i_last,
    output logic                        o_done,
    output logic signed [MEDIAN_W-1:0]  o_median_value,
    output logic [COUNT_OUT_W-1:0]      o_sample_count,
    output logic                        o_overflowed
);

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    // Sequencing of items and readout.
    mos_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_last   (i_last),
        .i_status (w_status),
        .o_cmd    (w_cmd),
        .busy     (busy)
    );

    // Sorted storage and result formation.
    mos_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_sample       (i_sample),
        .o_status       (w_status),
        .o_done         (o_done),
        .o_median_value (o_median_value),
        .o_sample_count (o_sample_count),
        .o_overflowed   (o_overflowed)
    );

endmodule

### src/mos_datapath.sv
// Datapath of the median-of-set unit: sorted chain of sample cells, fill
// count, drop flag and the registered result. Depends on mos_pkg.
module mos_datapath
    import mos_pkg::*;
(
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  t_dp_cmd                     i_cmd,
    input  logic signed [SAMPLE_W-1:0]  i_sample,
    output t_dp_status                  o_status,
    output logic                        o_done,
    output logic signed [MEDIAN_W-1:0]  o_median_value,
    output logic [COUNT_OUT_W-1:0]      o_sample_count,
    output logic                        o_overflowed
);

    logic signed [SAMPLE_W-1:0] r_cell [MAX_SAMPLES];
    logic signed [SAMPLE_W-1:0] n_cell [MAX_SAMPLES];
    logic [CNT_W-1:0]           r_count;
    logic [CNT_W-1:0]           n_count;
    logic                       r_drop;
    logic                       n_drop;
    logic                       r_done;
    logic signed [MEDIAN_W-1:0] r_median;
    logic [COUNT_OUT_W-1:0]     r_out_count;
    logic                       r_ovf;
    logic [MAX_SAMPLES-1:0]     w_gt;
    logic                       w_full;
    logic                       w_ins;
    logic signed [MEDIAN_W-1:0] w_median;

    assign w_full = (r_count == CNT_W'(MAX_SAMPLES));
    assign w_ins  = i_cmd.insert && !w_full;

    // Each cell decides on its own: it takes its left neighbor when that
    // neighbor moves right, the new sample at the insertion point, or it
    // takes its right neighbor during the readout shift. Equal samples stay
    // ahead of the new one because only strictly greater cells move.
    for (genvar i = 0; i < MAX_SAMPLES; i++) begin : g_cell
        assign w_gt[i] = (CNT_W'(i) < r_count) && (r_cell[i] > i_sample);

        always_comb begin
            n_cell[i] = r_cell[i];
            if (w_ins) begin
                if (i > 0 && w_gt[(i > 0) ? i - 1 : 0]) begin
                    n_cell[i] = r_cell[(i > 0) ? i - 1 : 0];
                end else if (w_gt[i] || (CNT_W'(i) == r_count)) begin
                    n_cell[i] = i_sample;
                end
            end else if (i_cmd.shift && i < MAX_SAMPLES - 1) begin
                n_cell[i] = r_cell[(i < MAX_SAMPLES - 1) ? i + 1 : i];
            end
        end
    end

    // Cell storage needs no reset; only cells below the count are used.
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < MAX_SAMPLES; i++) begin
            r_cell[i] <= n_cell[i];
        end
    end

    // Fill count and drop flag.
    always_comb begin
        n_count = r_count;
        n_drop  = r_drop;
        if (i_cmd.insert) begin
            if (w_full) begin
                n_drop = 1'b1;
            end else begin
                n_count = r_count + CNT_W'(1);
            end
        end
        if (i_cmd.emit) begin
            n_count = '0;
            n_drop  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_drop  <= 1'b0;
        end else begin
            r_count <= n_count;
            r_drop  <= n_drop;
        end
    end

    // After the shift the lower middle sample sits in cell 0 and the upper
    // one in cell 1. An odd count doubles the middle, an even count adds.
    always_comb begin
        if (r_count[0]) begin
            w_median = {r_cell[0], 1'b0};
        end else begin
            w_median = {r_cell[0][SAMPLE_W-1], r_cell[0]}
                     + {r_cell[1][SAMPLE_W-1], r_cell[1]};
        end
    end

    // Result register with its one-cycle strobe.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_cmd.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_median    <= w_median;
            r_out_count <= COUNT_OUT_W'(r_count);
            r_ovf       <= r_drop;
        end
    end

    assign o_status.count  = r_count;
    assign o_done          = r_done;
    assign o_median_value  = r_median;
    assign o_sample_count  = r_out_count;
    assign o_overflowed    = r_ovf;

    // The count never runs past capacity.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_SAMPLES))
        else $error("fill count exceeds capacity");

    // Closing a set clears the count and raises the strobe.
    a_emit_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |=> (r_count == '0) && !r_drop && r_done)
        else $error("set not closed after emit");

    // An item below capacity grows the count by one.
    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.insert && !w_full) |=> r_count == $past(r_count) + CNT_W'(1))
        else $error("count did not advance on insert");

endmodule

### src/mos_ctrl.sv
// Controller of the median-of-set unit: accepts items and, at the end of a
// set, sequences the readout shift and the result. Depends on mos_pkg.
module mos_ctrl
    import mos_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    input  logic        i_last,
    input  t_dp_status  i_status,
    output t_dp_cmd     o_cmd,
    output logic        busy
);

    t_state              r_state;
    t_state              n_state;
    logic [SHIFT_W-1:0]  r_sh;
    logic [SHIFT_W-1:0]  n_sh;

    // State and shift counter registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_sh    <= '0;
        end else begin
            r_state <= n_state;
            r_sh    <= n_sh;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state      = r_state;
        n_sh         = r_sh;
        o_cmd.insert = 1'b0;
        o_cmd.shift  = 1'b0;
        o_cmd.emit   = 1'b0;
        busy         = 1'b1;
        case (r_state)
            ST_IDLE: begin
                busy = 1'b0;
                if (start) begin
                    o_cmd.insert = 1'b1;
                    if (i_last) begin
                        n_state = ST_LOAD;
                    end
                end
            end
            ST_LOAD: begin
                // Shift so that the lower middle sample lands in cell 0.
                n_sh    = SHIFT_W'((i_status.count - CNT_W'(1)) >> 1);
                n_state = ST_SHIFT;
            end
            ST_SHIFT: begin
                if (r_sh == '0) begin
                    n_state = ST_EMIT;
                end else begin
                    o_cmd.shift = 1'b1;
                    n_sh        = r_sh - SHIFT_W'(1);
                end
            end
            ST_EMIT: begin
                o_cmd.emit = 1'b1;
                n_state    = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // A last-marked item always starts the readout.
    a_last_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_last) |=> r_state == ST_LOAD)
        else $error("last item did not start readout");

    // An exhausted shift counter leads straight to the result.
    a_shift_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SHIFT && r_sh == '0) |=> r_state == ST_EMIT)
        else $error("shift phase did not end");

    // The counter only moves down while shifting.
    a_shift_dec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.shift |=> r_sh == $past(r_sh) - SHIFT_W'(1))
        else $error("shift counter misstep");

endmodule

### dv/median_checker.sv
`timescale 1ns / 1ps
// Checker for the median-of-set unit: watches the item and result channels,
// keeps its own sorted copy of each set and compares every median it sees.
// Depends on mos_pkg for the field widths and the capacity.
module median_checker
    import mos_pkg::*;
(
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic                        i_busy,
    input  logic signed [SAMPLE_W-1:0]  i_sample,
    input  logic                        i_last,
    input  logic                        i_done,
    input  logic signed [MEDIAN_W-1:0]  i_median_value,
    input  logic [COUNT_OUT_W-1:0]      i_sample_count,
    input  logic                        i_overflowed,
    output int                          o_fail_count,
    output int                          o_pending
);

    // One median result as the unit should report it.
    typedef struct {
        logic signed [MEDIAN_W-1:0] median;
        logic [COUNT_OUT_W-1:0]     count;
        logic                       dropped;
    } t_median_result;

    // Predicted contents of the sorted chain for the set now open.
    logic signed [SAMPLE_W-1:0] set_sorted [MAX_SAMPLES];
    int                         set_kept;
    logic                       set_dropped;

    t_median_result expected_medians [$];
    int             fail_count;

    assign o_fail_count = fail_count;
    assign o_pending    = expected_medians.size();

    // Counts a failure and reports only the first ten of them.
    function automatic void note_failure(input string what);
        fail_count++;
        if (fail_count <= 10) begin
            $display("[%0t] median check: %s", $realtime, what);
        end
    endfunction

    // Places a sample after every kept sample that is not greater than it.
    function automatic void insert_sample(input logic signed [SAMPLE_W-1:0] value);
        int pos;
        pos = set_kept;
        while (pos > 0 && set_sorted[pos-1] > value) begin
            set_sorted[pos] = set_sorted[pos-1];
            pos--;
        end
        set_sorted[pos] = value;
        set_kept++;
    endfunction

    // Closes the set: the median carries one more fraction bit, so an odd
    // set gives twice the middle sample and an even set the sum of the two.
    function automatic t_median_result close_set();
        t_median_result res;
        int             mid;
        mid = set_kept / 2;
        if (set_kept[0]) begin
            res.median = {set_sorted[mid], 1'b0};
        end else begin
            res.median = {set_sorted[mid][SAMPLE_W-1], set_sorted[mid]}
                       + {set_sorted[mid-1][SAMPLE_W-1], set_sorted[mid-1]};
        end
        res.count   = COUNT_OUT_W'(set_kept);
        res.dropped = set_dropped;
        return res;
    endfunction

    // Items are taken when start is high and busy is low; the unit gives
    // each result for a single cycle, marked by done.
    always @(posedge i_clk) begin
        t_median_result want;
        if (!i_rst_n) begin
            set_kept    = 0;
            set_dropped = 1'b0;
            expected_medians.delete();
            fail_count  = 0;
        end else begin
            if (i_done) begin
                if (expected_medians.size() == 0) begin
                    note_failure($sformatf(
                        "result with none expected: median %0d count %0d overflow %0b",
                        i_median_value, i_sample_count, i_overflowed));
                end else begin
                    want = expected_medians.pop_front();
                    if (want.median !== i_median_value || want.count !== i_sample_count ||
                        want.dropped !== i_overflowed) begin
                        note_failure($sformatf(
                            "expected median %0d count %0d overflow %0b, got %0d %0d %0b",
                            want.median, want.count, want.dropped,
                            i_median_value, i_sample_count, i_overflowed));
                    end
                end
            end
            if (i_start && !i_busy) begin
                if (set_kept < MAX_SAMPLES) begin
                    insert_sample(i_sample);
                end else begin
                    set_dropped = 1'b1;
                end
                if (i_last) begin
                    expected_medians = {expected_medians, close_set()};
                    set_kept    = 0;
                    set_dropped = 1'b0;
                end
            end
        end
    end

endmodule

### dv/testbench.sv
`timescale 1ns / 1ps
// Top of the median-of-set regression: clock, reset, sample stimulus and
// the verdict. Depends on mos_pkg, median_of_set_unit and median_checker.
module testbench
    import mos_pkg::*;
();

    localparam int SET_ITEMS   = 1900;
    localparam int CYCLE_LIMIT = 500000;
    localparam int TAIL_CYCLES = 48;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       start = 1'b0;
    logic                       busy;
    logic signed [SAMPLE_W-1:0] i_sample = '0;
    logic                       i_last = 1'b0;
    logic                       o_done;
    logic signed [MEDIAN_W-1:0] o_median_value;
    logic [COUNT_OUT_W-1:0]     o_sample_count;
    logic                       o_overflowed;
    int                         fail_count;
    int                         pending;
    int                         cycle_count = 0;
    int                         items_sent = 0;

    median_of_set_unit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_sample       (i_sample),
        .i_last         (i_last),
        .o_done         (o_done),
        .o_median_value (o_median_value),
        .o_sample_count (o_sample_count),
        .o_overflowed   (o_overflowed)
    );

    median_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_busy         (busy),
        .i_sample       (i_sample),
        .i_last         (i_last),
        .i_done         (o_done),
        .i_median_value (o_median_value),
        .i_sample_count (o_sample_count),
        .i_overflowed   (o_overflowed),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    always #6 i_clk = ~i_clk;

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("median_of_set_unit regression: fail");
            $finish;
        end
    end

    // Drives one item at a falling edge and holds it until the unit takes it.
    task automatic send_sample(input logic [SAMPLE_W-1:0] value, input logic mark,
                               input int gap);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start    <= 1'b1;
        i_sample <= value;
        i_last   <= mark;
        do @(posedge i_clk); while (busy);
        @(negedge i_clk);
        items_sent++;
    endtask

    // Stops sending until every expected median has come back.
    task automatic drain_results();
        start <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
    endtask

    // Mixes full-range values, small values, repeats, extremes and
    // whole-number Q16.16 values so that equal samples occur often.
    function automatic logic [SAMPLE_W-1:0] pick_sample(input logic [SAMPLE_W-1:0] prev);
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return $urandom;
            5, 6:          return SAMPLE_W'($urandom_range(0, 511)) - SAMPLE_W'(256);
            7:             return prev;
            8: begin
                case ($urandom_range(0, 3))
                    0:       return 32'h7FFF_FFFF;
                    1:       return 32'h8000_0000;
                    2:       return 32'h0000_0000;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
            default:       return $urandom & 32'hFFFF_0000;
        endcase
    endfunction

    initial begin
        logic [SAMPLE_W-1:0] value;
        int                  set_index;
        int                  set_size;
        int                  pick;
        bit                  burst;

        value = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed sets: single extremes, pairs of extremes, equal samples
        // and a short even set with mixed signs.
        send_sample(32'h7FFF_FFFF, 1'b1, 0);
        send_sample(32'h8000_0000, 1'b1, 3);
        send_sample(32'h7FFF_FFFF, 1'b0, 0);
        send_sample(32'h7FFF_FFFF, 1'b1, 0);
        send_sample(32'h8000_0000, 1'b0, 1);
        send_sample(32'h8000_0000, 1'b1, 0);
        send_sample(32'h7FFF_FFFF, 1'b0, 0);
        send_sample(32'h8000_0000, 1'b1, 2);
        send_sample(32'h0005_0000, 1'b0, 0);
        send_sample(32'hFFFD_0000, 1'b0, 0);
        send_sample(32'h0005_0000, 1'b1, 0);
        send_sample(32'h0000_0001, 1'b0, 5);
        send_sample(32'hFFFF_FFFF, 1'b0, 0);
        send_sample(32'h0000_0000, 1'b0, 0);
        send_sample(32'h0000_0003, 1'b1, 0);
        send_sample(32'h0000_0007, 1'b0, 0);
        send_sample(32'h0000_0007, 1'b0, 0);
        send_sample(32'h0000_0007, 1'b0, 0);
        send_sample(32'h0000_0002, 1'b1, 0);
        drain_results();

        // Random sets: the first ones fill the chain exactly, overflow it on
        // the last-marked item and overflow it well before the end.
        set_index = 0;
        while (items_sent < SET_ITEMS) begin
            pick = $urandom_range(0, 19);
            if (set_index == 0) begin
                set_size = MAX_SAMPLES;
            end else if (set_index == 1) begin
                set_size = MAX_SAMPLES + 1;
            end else if (set_index == 2) begin
                set_size = MAX_SAMPLES + 6;
            end else if (pick == 0) begin
                set_size = $urandom_range(MAX_SAMPLES - 4, MAX_SAMPLES + 16);
            end else if (pick <= 2) begin
                set_size = $urandom_range(1, 2);
            end else begin
                set_size = $urandom_range(1, 12);
            end
            burst = ($urandom_range(0, 3) == 0);
            for (int j = 0; j < set_size; j++) begin
                value = pick_sample(value);
                send_sample(value, j == set_size - 1, burst ? 0 : $urandom_range(0, 19));
            end
            if (set_index == 40) begin
                drain_results();
            end
            set_index++;
        end

        // Let the last median come out, then watch for stray results.
        drain_results();
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("median_of_set_unit regression: pass");
        end else begin
            $display("median_of_set_unit regression: fail");
        end
        $finish;
    end

endmodule
